[rtl/ridi_pkg.sv]
// ridi_pkg: widths, register indexes and shared types for the ray/disc intersection block.
// Used by every module under rtl/ except ridi_fifo; depends on nothing else.
package ridi_pkg;

   // field widths
   localparam int COORD_W = 32;
   localparam int NORM_W  = 18;
   localparam int RAD_W   = 31;

   // front arithmetic widths
   localparam int CMO_W   = COORD_W + 1;            // center minus origin
   localparam int NUMP_W  = CMO_W + NORM_W;         // one numerator term
   localparam int DENP_W  = COORD_W + NORM_W;       // one denominator term
   localparam int NUM_W   = NUMP_W + 2;             // sum of three terms
   localparam int DEN_W   = DENP_W + 2;
   localparam int NMAG_W  = NUM_W;
   localparam int DMAG_W  = DEN_W;

   // divider widths
   localparam int QUO_W   = COORD_W + 1;            // quotient bits worked out
   localparam int REM_W   = DMAG_W + 1;

   // hit point widths
   localparam int PROD_W  = 2 * COORD_W;
   localparam int DIFF_W  = PROD_W + 2;
   localparam int SQ_W    = 2 * RAD_W;
   localparam int SUM_W   = SQ_W + 2;

   // saturation limits of t
   localparam logic [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // queue between front and back
   localparam int QDEPTH  = 8;
   localparam int CNT_W   = $clog2(QDEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS   = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NORM_W-1:0]  norm_type;
   typedef logic [RAD_W-1:0]          rad_type;

   typedef struct packed {
      coord_type [2:0] center;
      norm_type  [2:0] normal;
      rad_type         radius;
   } cfg_type;

   // one classified request, as handed from front to back
   typedef struct packed {
      coord_type [2:0]   org;
      coord_type [2:0]   dir;
      logic [NMAG_W-1:0] num_mag;
      logic [DMAG_W-1:0] den_mag;
      logic              neg;
      logic              den_zero;
   } entry_type;

   // one stage of the divider pipeline
   typedef struct packed {
      coord_type [2:0]   org;
      coord_type [2:0]   dir;
      logic [NMAG_W-1:0] num_mag;
      logic [DMAG_W-1:0] den_mag;
      logic              neg;
      logic              den_zero;
      logic              sat;
      logic [REM_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
   } div_type;

endpackage

[rtl/ridi_fifo.sv]
// ridi_fifo: small flop-based queue between front and back, head shown directly.
// Depends on nothing; DEPTH must be a power of two, overflow guarded by the caller.
module ridi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]   rd_ptr_ff, rd_ptr_in;

   // advance pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (PTR_W+1)'(push);
      rd_ptr_in = rd_ptr_ff + (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[PTR_W-1:0]] <= data_in;
      end
   end

   assign data_out = mem_ff[rd_ptr_ff[PTR_W-1:0]];
   assign empty    = (wr_ptr_ff == rd_ptr_ff);

endmodule

[rtl/ridi_front.sv]
// ridi_front: forms numerator and denominator dot products and classifies each request.
// Depends on ridi_pkg; feeds ridi_fifo, never stalls.
module ridi_front import ridi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  coord_type [2:0] in_org,
   input  coord_type [2:0] in_dir,
   input  cfg_type         cfg,
   output logic            out_valid,
   output entry_type       out_entry
);
   // stage A: products
   logic                     a_valid_ff;
   coord_type [2:0]          a_org_ff, a_dir_ff;
   logic signed [NUMP_W-1:0] a_nump_ff [3];
   logic signed [NUMP_W-1:0] a_nump_in [3];
   logic signed [DENP_W-1:0] a_denp_ff [3];
   logic signed [DENP_W-1:0] a_denp_in [3];

   // stage B: sums
   logic                    b_valid_ff;
   coord_type [2:0]         b_org_ff, b_dir_ff;
   logic signed [NUM_W-1:0] b_num_ff, b_num_in;
   logic signed [DEN_W-1:0] b_den_ff, b_den_in;

   // stage C: classified request
   logic      c_valid_ff;
   entry_type c_entry_ff, c_entry_in;

   // multiply each term
   always_comb begin
      logic signed [CMO_W-1:0] cmo [3];
      for (int i = 0; i < 3; i++) begin
         cmo[i] = CMO_W'($signed(cfg.center[i])) - CMO_W'($signed(in_org[i]));
         a_nump_in[i] = NUMP_W'(cmo[i]) * NUMP_W'($signed(cfg.normal[i]));
         a_denp_in[i] = DENP_W'($signed(in_dir[i])) * DENP_W'($signed(cfg.normal[i]));
      end
   end

   // sum the terms
   always_comb begin
      b_num_in = NUM_W'(a_nump_ff[0]) + NUM_W'(a_nump_ff[1]) + NUM_W'(a_nump_ff[2]);
      b_den_in = DEN_W'(a_denp_ff[0]) + DEN_W'(a_denp_ff[1]) + DEN_W'(a_denp_ff[2]);
   end

   // take magnitudes and sign of the quotient
   always_comb begin
      c_entry_in.org      = b_org_ff;
      c_entry_in.dir      = b_dir_ff;
      c_entry_in.neg      = b_num_ff[NUM_W-1] ^ b_den_ff[DEN_W-1];
      c_entry_in.den_zero = (b_den_ff == '0);
      c_entry_in.num_mag  = b_num_ff[NUM_W-1] ? NMAG_W'(-b_num_ff) : NMAG_W'(b_num_ff);
      c_entry_in.den_mag  = b_den_ff[DEN_W-1] ? DMAG_W'(-b_den_ff) : DMAG_W'(b_den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_org_ff   <= in_org;
      a_dir_ff   <= in_dir;
      a_nump_ff  <= a_nump_in;
      a_denp_ff  <= a_denp_in;
      b_org_ff   <= a_org_ff;
      b_dir_ff   <= a_dir_ff;
      b_num_ff   <= b_num_in;
      b_den_ff   <= b_den_in;
      c_entry_ff <= c_entry_in;
   end

   assign out_valid = c_valid_ff;
   assign out_entry = c_entry_ff;

endmodule

[rtl/ridi_back.sv]
// ridi_back: divider pipeline, hit point and radius test, result register.
// Depends on ridi_pkg; pulls requests from ridi_fifo, stalls as a whole on the result side.
module ridi_back import ridi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  entry_type q_head,
   input  logic      q_empty,
   output logic      q_pop,
   input  cfg_type   cfg,
   input  logic      rsp_pop,
   output logic      rsp_empty,
   output logic      rsp_hit,
   output coord_type rsp_distance_t
);
   localparam int NSH_W = NMAG_W + FRAC_BITS;
   localparam int HI_W  = NSH_W - QUO_W;
   localparam int CMP_W = (HI_W > REM_W) ? HI_W : REM_W;

   logic adv;

   // divider pipeline: index 0 is the pre-check stage
   logic [QUO_W:0] div_v_ff, div_v_in;
   div_type        div_ff [QUO_W+1];
   div_type        div_in [QUO_W+1];

   // t stage
   logic            t_v_ff;
   coord_type       t_ff, t_in;
   coord_type [2:0] t_org_ff, t_dir_ff;
   logic            t_dz_ff;

   // product stage
   logic                     m1_v_ff;
   logic signed [PROD_W-1:0] m1_prod_ff [3];
   logic signed [PROD_W-1:0] m1_prod_in [3];
   coord_type [2:0]          m1_org_ff;
   coord_type                m1_t_ff;
   logic                     m1_dz_ff;

   // offset stage
   logic                     m2_v_ff;
   logic signed [DIFF_W-1:0] m2_diff_ff [3];
   logic signed [DIFF_W-1:0] m2_diff_in [3];
   coord_type                m2_t_ff;
   logic                     m2_dz_ff;

   // magnitude stage
   logic             m3_v_ff;
   logic [RAD_W-1:0] m3_abs_ff [3];
   logic [RAD_W-1:0] m3_abs_in [3];
   logic             m3_miss_ff, m3_miss_in;
   coord_type        m3_t_ff;
   logic             m3_dz_ff;

   // square stage
   logic            m4_v_ff;
   logic [SQ_W-1:0] m4_sq_ff [3];
   logic [SQ_W-1:0] m4_sq_in [3];
   logic            m4_miss_ff;
   coord_type       m4_t_ff;
   logic            m4_dz_ff;

   // result register
   logic            rsp_valid_ff;
   logic            rsp_hit_ff, rsp_hit_in;
   coord_type       rsp_t_ff;
   logic [SQ_W-1:0] rad_sq_ff;
   logic [SUM_W-1:0] sq_sum;

   // advance everything while the result register is free or being taken
   assign adv   = !rsp_valid_ff || rsp_pop;
   assign q_pop = adv && !q_empty;

   // pre-check: quotient would need more than QUO_W bits
   always_comb begin
      logic [NSH_W-1:0] nsh;
      logic [HI_W-1:0]  hi;
      nsh = {q_head.num_mag, FRAC_BITS'(0)};
      hi  = nsh[NSH_W-1:QUO_W];
      div_in[0].org      = q_head.org;
      div_in[0].dir      = q_head.dir;
      div_in[0].num_mag  = q_head.num_mag;
      div_in[0].den_mag  = q_head.den_mag;
      div_in[0].neg      = q_head.neg;
      div_in[0].den_zero = q_head.den_zero;
      div_in[0].sat      = CMP_W'(hi) >= CMP_W'(q_head.den_mag);
      div_in[0].rem      = REM_W'(hi);
      div_in[0].quo      = '0;
      div_v_in[0]        = !q_empty;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      always_comb begin
         logic [NSH_W-1:0] nsh;
         logic [REM_W-1:0] r2;
         logic             ge;
         nsh = {div_ff[k].num_mag, FRAC_BITS'(0)};
         r2  = {div_ff[k].rem[REM_W-2:0], nsh[QUO_W-1-k]};
         ge  = r2 >= REM_W'(div_ff[k].den_mag);
         div_in[k+1]     = div_ff[k];
         div_in[k+1].rem = ge ? (r2 - REM_W'(div_ff[k].den_mag)) : r2;
         div_in[k+1].quo = {div_ff[k].quo[QUO_W-2:0], ge};
         div_v_in[k+1]   = div_v_ff[k];
      end
   end

   // saturate and sign t
   always_comb begin
      logic [QUO_W-1:0] lim;
      logic             sat;
      logic             neg;
      neg = div_ff[QUO_W].neg;
      lim = neg ? QUO_W'(T_MIN) : QUO_W'(T_MAX);
      sat = div_ff[QUO_W].sat || (div_ff[QUO_W].quo > lim);
      if (sat) begin
         t_in = neg ? T_MIN : T_MAX;
      end else if (neg) begin
         t_in = -COORD_W'(div_ff[QUO_W].quo);
      end else begin
         t_in = COORD_W'(div_ff[QUO_W].quo);
      end
   end

   // t times direction
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m1_prod_in[i] = PROD_W'(t_ff) * PROD_W'($signed(t_dir_ff[i]));
      end
   end

   // hit point minus center
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m2_diff_in[i] = DIFF_W'($signed(m1_org_ff[i])) - DIFF_W'($signed(cfg.center[i]))
                       + DIFF_W'(m1_prod_ff[i] >>> FRAC_BITS);
      end
   end

   // magnitude and per-axis radius check
   always_comb begin
      logic [DIFF_W-1:0] mag;
      m3_miss_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag = m2_diff_ff[i][DIFF_W-1] ? DIFF_W'(-m2_diff_ff[i]) : DIFF_W'(m2_diff_ff[i]);
         m3_abs_in[i] = mag[RAD_W-1:0];
         if (mag >= DIFF_W'(cfg.radius)) begin
            m3_miss_in = 1'b1;
         end
      end
   end

   // square each axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m4_sq_in[i] = SQ_W'(m3_abs_ff[i]) * SQ_W'(m3_abs_ff[i]);
      end
   end

   // final distance test
   always_comb begin
      sq_sum     = SUM_W'(m4_sq_ff[0]) + SUM_W'(m4_sq_ff[1]) + SUM_W'(m4_sq_ff[2]);
      rsp_hit_in = !m4_dz_ff && !m4_miss_ff && (sq_sum < SUM_W'(rad_sq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff     <= '0;
         t_v_ff       <= 1'b0;
         m1_v_ff      <= 1'b0;
         m2_v_ff      <= 1'b0;
         m3_v_ff      <= 1'b0;
         m4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         div_v_ff     <= div_v_in;
         t_v_ff       <= div_v_ff[QUO_W];
         m1_v_ff      <= t_v_ff;
         m2_v_ff      <= m1_v_ff;
         m3_v_ff      <= m2_v_ff;
         m4_v_ff      <= m3_v_ff;
         rsp_valid_ff <= m4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rad_sq_ff <= SQ_W'(cfg.radius) * SQ_W'(cfg.radius);
      if (adv) begin
         div_ff     <= div_in;
         t_ff       <= t_in;
         t_org_ff   <= div_ff[QUO_W].org;
         t_dir_ff   <= div_ff[QUO_W].dir;
         t_dz_ff    <= div_ff[QUO_W].den_zero;
         m1_prod_ff <= m1_prod_in;
         m1_org_ff  <= t_org_ff;
         m1_t_ff    <= t_ff;
         m1_dz_ff   <= t_dz_ff;
         m2_diff_ff <= m2_diff_in;
         m2_t_ff    <= m1_t_ff;
         m2_dz_ff   <= m1_dz_ff;
         m3_abs_ff  <= m3_abs_in;
         m3_miss_ff <= m3_miss_in;
         m3_t_ff    <= m2_t_ff;
         m3_dz_ff   <= m2_dz_ff;
         m4_sq_ff   <= m4_sq_in;
         m4_miss_ff <= m3_miss_ff;
         m4_t_ff    <= m3_t_ff;
         m4_dz_ff   <= m3_dz_ff;
         rsp_hit_ff <= rsp_hit_in;
         rsp_t_ff   <= m4_t_ff;
      end
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_distance_t = rsp_hit_ff ? rsp_t_ff : '0;

endmodule

[rtl/ray_disc_intersect.sv]
// ray_disc_intersect: top level; configuration registers, front, queue and back.
// Depends on ridi_pkg, ridi_front, ridi_fifo and ridi_back.
//
//   channel   handshake         payload
//   request   push / full       req_origin_x/y/z, req_dir_x/y/z
//   result    pop / empty       rsp_hit, rsp_distance_t
//   config    csr_we            csr_idx, csr_wdata
//
// One request per cycle sustained while results are popped and the queue is not
// full; the back holds a radix-2 divider, which works out one quotient bit per pipeline stage.
// Reset is synchronous and clears all control state at once; no clearing pass.
// A waiting result stalls the back only; the front keeps taking requests
// until front and queue together hold QDEPTH requests.
module ray_disc_intersect import ridi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [COORD_W-1:0]   req_origin_x,
   input  logic [COORD_W-1:0]   req_origin_y,
   input  logic [COORD_W-1:0]   req_origin_z,
   input  logic [COORD_W-1:0]   req_dir_x,
   input  logic [COORD_W-1:0]   req_dir_y,
   input  logic [COORD_W-1:0]   req_dir_z,
   output logic                 empty,
   input  logic                 pop,
   output logic                 rsp_hit,
   output logic [COORD_W-1:0]   rsp_distance_t,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [COORD_W-1:0]   csr_wdata
);
   cfg_type         cfg_ff, cfg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            accept;
   coord_type [2:0] in_org, in_dir;
   logic            f_valid;
   entry_type       f_entry;
   entry_type       q_head;
   logic [$bits(entry_type)-1:0] q_data;
   logic            q_empty;
   logic            q_pop;
   coord_type       distance_t;

   // write configuration
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx)
            REG_CENTER_X: cfg_in.center[0] = csr_wdata;
            REG_CENTER_Y: cfg_in.center[1] = csr_wdata;
            REG_CENTER_Z: cfg_in.center[2] = csr_wdata;
            REG_NORMAL_X: cfg_in.normal[0] = csr_wdata[NORM_W-1:0];
            REG_NORMAL_Y: cfg_in.normal[1] = csr_wdata[NORM_W-1:0];
            REG_NORMAL_Z: cfg_in.normal[2] = csr_wdata[NORM_W-1:0];
            REG_RADIUS:   cfg_in.radius    = csr_wdata[RAD_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center <= '0;
         cfg_ff.normal <= {NORM_W'(0), NORM_W'(1) << FRAC_BITS, NORM_W'(0)};
         cfg_ff.radius <= RAD_W'(1) << FRAC_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // count requests held by front and queue
   assign accept = push && !full;
   assign cnt_in = cnt_ff + CNT_W'(accept) - CNT_W'(q_pop);
   assign full   = (cnt_ff == CNT_W'(QDEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign in_org = {req_origin_z, req_origin_y, req_origin_x};
   assign in_dir = {req_dir_z, req_dir_y, req_dir_x};

   ridi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_org    (in_org),
      .in_dir    (in_dir),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_entry (f_entry)
   );

   ridi_fifo #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .data_in  (f_entry),
      .pop      (q_pop),
      .data_out (q_data),
      .empty    (q_empty)
   );

   assign q_head = entry_type'(q_data);

   ridi_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .cfg            (cfg_ff),
      .rsp_pop        (pop),
      .rsp_empty      (empty),
      .rsp_hit        (rsp_hit),
      .rsp_distance_t (distance_t)
   );

   assign rsp_distance_t = distance_t;

endmodule
